/* hdl/mmt_pkg.sv */
// ============================================================================
// mmt_pkg
// Shared types and codes for the single-precision matrix product engine.
// ============================================================================
`default_nettype none

package mmt_pkg;

    // request codes
    localparam logic [1:0] REQ_WR_A = 2'd0;
    localparam logic [1:0] REQ_WR_B = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // layout codes (the unused code behaves as plain A times B)
    localparam logic [1:0] LAYOUT_AB  = 2'd0;
    localparam logic [1:0] LAYOUT_ATB = 2'd1;
    localparam logic [1:0] LAYOUT_ABT = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_DIM_M  = 2'd0;
    localparam logic [1:0] REG_DIM_K  = 2'd1;
    localparam logic [1:0] REG_DIM_N  = 2'd2;
    localparam logic [1:0] REG_LAYOUT = 2'd3;

    localparam int DIM_W   = 7;    // dimension register width
    localparam int ADDR_XW = 14;   // widest element address of a 127x127 matrix
    localparam int EXP_W   = 12;   // signed working exponent
    localparam int SUM_W   = 50;   // adder / normalizer mantissa width

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_FETCH,
        S_MUL,
        S_MNORM,
        S_MRND,
        S_ADD,
        S_ANORM,
        S_ARND,
        S_DONE
    } state_t;

    // class of a floating-point operation result
    typedef enum logic [1:0] {
        FK_NUM,
        FK_ZERO,
        FK_INF,
        FK_NAN
    } fkind_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // latch read request, clear accumulator
        logic rd;        // read one A/B pair, advance addresses
        logic mul;       // multiply stage
        logic norm;      // normalize stage
        logic norm_add;  // normalizer takes the adder (else the multiplier)
        logic prod_en;   // capture rounded product
        logic add;       // align and add stage
        logic acc_en;    // capture rounded sum
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic bad;         // row or column out of range
        logic terms_done;  // all K terms fetched
    } dp_stat_t;

endpackage

`default_nettype wire

/* hdl/mmt_ctrl.sv */
// ============================================================================
// mmt_ctrl
// Sequencer for the matrix product engine: walks each read through the
// fetch, multiply, normalize, round, add, normalize, round steps each term.
// ============================================================================
`default_nettype none

module mmt_ctrl
    import mmt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] req_type,
    input  dp_stat_t   stat,
    output logic       busy,
    output logic       done,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && req_type == REQ_READ)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.bad || stat.terms_done)
                    state_next = S_DONE;
                else
                    state_next = S_FETCH;
            end
            S_FETCH: state_next = S_MUL;
            S_MUL:   state_next = S_MNORM;
            S_MNORM: state_next = S_MRND;
            S_MRND:  state_next = S_ADD;
            S_ADD:   state_next = S_ANORM;
            S_ANORM: state_next = S_ARND;
            S_ARND:
            begin
                if (stat.terms_done)
                    state_next = S_DONE;
                else
                    state_next = S_FETCH;
            end
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd          = '0;
        busy         = 1'b1;
        done         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start && req_type == REQ_READ;
            end
            S_FETCH: cmd.rd = 1'b1;
            S_MUL:   cmd.mul = 1'b1;
            S_MNORM: cmd.norm = 1'b1;
            S_MRND:  cmd.prod_en = 1'b1;
            S_ADD:   cmd.add = 1'b1;
            S_ANORM:
            begin
                cmd.norm     = 1'b1;
                cmd.norm_add = 1'b1;
            end
            S_ARND:  cmd.acc_en = 1'b1;
            S_DONE:  done = 1'b1;
            default: busy = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

/* hdl/mmt_datapath.sv */
// ============================================================================
// mmt_datapath
// Configuration registers, A and B element stores, address walk and the
// single-precision multiply / add path with a shared normalize-round unit.
// ============================================================================
`default_nettype none

module mmt_datapath
    import mmt_pkg::*;
#(
    parameter int MAX_DIM = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        accept,
    input  logic [1:0]  req_type,
    input  logic [11:0] elem_index,
    input  logic [31:0] elem_value,
    input  logic [5:0]  out_row,
    input  logic [5:0]  out_col,
    input  ctrl_cmd_t   cmd,
    output dp_stat_t    stat,
    output logic [31:0] result_value,
    output logic [5:0]  result_row,
    output logic [5:0]  result_col,
    output logic        index_error
);

    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW          = $clog2(STORE_DEPTH);

    // count of leading zeros over the adder width
    function automatic logic [5:0] lzc(input logic [SUM_W-1:0] v);
        logic [5:0] n;
        logic       found;
        n     = '0;
        found = 1'b0;
        for (int i = SUM_W - 1; i >= 0; i--)
        begin
            if (!found)
            begin
                if (v[i])
                    found = 1'b1;
                else
                    n = n + 6'd1;
            end
        end
        return n;
    endfunction

    // round to nearest even and pack; m has its leading one at bit 47
    function automatic logic [31:0] round_pack(
        input logic                    sgn,
        input logic signed [EXP_W-1:0] e,
        input logic [47:0]             m,
        input logic                    stk
    );
        logic [95:0]      wide;
        logic [47:0]      ms;
        logic             sk;
        logic [7:0]       eadj;
        logic [EXP_W-1:0] sh;
        logic [23:0]      m24;
        logic             rnd;
        logic [31:0]      sum;
        if (e > 12'sd0)
        begin
            wide = '0;
            sh   = '0;
            ms   = m;
            sk   = stk;
            eadj = 8'(e - 12'sd1);
        end
        else
        begin
            // subnormal: denormalize with sticky collection
            sh   = EXP_W'(-e) + EXP_W'(1);
            wide = {m, 48'b0} >> sh;
            ms   = wide[95:48];
            sk   = stk | (|wide[47:0]);
            eadj = '0;
        end
        m24 = ms[47:24];
        rnd = ms[23] & (sk | (|ms[22:0]) | m24[0]);
        sum = {1'b0, eadj, 23'b0} + {8'b0, m24} + 32'(rnd);
        if (e >= 12'sd255)
            round_pack = {sgn, 8'hFF, 23'b0};
        else
            round_pack = {sgn, sum[30:0]};
    endfunction

    // ---------------- configuration ----------------
    logic [DIM_W-1:0] dim_m_reg, dim_k_reg, dim_n_reg;
    logic [1:0]       layout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_m_reg  <= DIM_W'(1);
            dim_k_reg  <= DIM_W'(1);
            dim_n_reg  <= DIM_W'(1);
            layout_reg <= LAYOUT_AB;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_DIM_M:  dim_m_reg  <= cfg_data;
                REG_DIM_K:  dim_k_reg  <= cfg_data;
                REG_DIM_N:  dim_n_reg  <= cfg_data;
                REG_LAYOUT: layout_reg <= cfg_data[1:0];
                default:    dim_m_reg  <= dim_m_reg;
            endcase
        end
    end

    // dimensions clamped to the store size
    logic [DIM_W-1:0]   m_eff, k_eff, n_eff;
    logic [ADDR_XW-1:0] mk_size, kn_size;

    assign m_eff   = (32'(dim_m_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : dim_m_reg;
    assign k_eff   = (32'(dim_k_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : dim_k_reg;
    assign n_eff   = (32'(dim_n_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : dim_n_reg;
    assign mk_size = ADDR_XW'(m_eff) * ADDR_XW'(k_eff);
    assign kn_size = ADDR_XW'(k_eff) * ADDR_XW'(n_eff);

    // ---------------- element stores ----------------
    logic wr_a, wr_b;
    logic idx_in_store;

    assign idx_in_store = 32'(elem_index) < STORE_DEPTH;
    assign wr_a = accept && req_type == REQ_WR_A && idx_in_store
                  && ADDR_XW'(elem_index) < mk_size;
    assign wr_b = accept && req_type == REQ_WR_B && idx_in_store
                  && ADDR_XW'(elem_index) < kn_size;

    logic [31:0]        a_mem [STORE_DEPTH];
    logic [31:0]        b_mem [STORE_DEPTH];
    logic [31:0]        a_rd_reg, b_rd_reg;
    logic [ADDR_XW-1:0] a_addr_reg, b_addr_reg;

    always_ff @(posedge clk)
    begin
        if (wr_a)
            a_mem[AW'(elem_index)] <= elem_value;
        if (cmd.rd)
            a_rd_reg <= a_mem[AW'(a_addr_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (wr_b)
            b_mem[AW'(elem_index)] <= elem_value;
        if (cmd.rd)
            b_rd_reg <= b_mem[AW'(b_addr_reg)];
    end

    // ---------------- request latch and address walk ----------------
    logic [ADDR_XW-1:0] a_step_reg, b_step_reg;
    logic [DIM_W-1:0]   term_reg;
    logic [5:0]         row_reg, col_reg;
    logic               bad_reg;
    logic               bad_next;

    assign bad_next = (DIM_W'(out_row) >= m_eff) || (DIM_W'(out_col) >= n_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg <= '0;
            bad_reg  <= 1'b0;
        end
        else if (cmd.load)
        begin
            term_reg <= '0;
            bad_reg  <= bad_next;
        end
        else if (cmd.rd)
        begin
            term_reg <= term_reg + DIM_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            row_reg <= out_row;
            col_reg <= out_col;
            if (layout_reg == LAYOUT_ATB)
            begin
                a_addr_reg <= ADDR_XW'(out_row);
                a_step_reg <= ADDR_XW'(m_eff);
            end
            else
            begin
                a_addr_reg <= ADDR_XW'(out_row) * ADDR_XW'(k_eff);
                a_step_reg <= ADDR_XW'(1);
            end
            if (layout_reg == LAYOUT_ABT)
            begin
                b_addr_reg <= ADDR_XW'(out_col) * ADDR_XW'(k_eff);
                b_step_reg <= ADDR_XW'(1);
            end
            else
            begin
                b_addr_reg <= ADDR_XW'(out_col);
                b_step_reg <= ADDR_XW'(n_eff);
            end
        end
        else if (cmd.rd)
        begin
            a_addr_reg <= a_addr_reg + a_step_reg;
            b_addr_reg <= b_addr_reg + b_step_reg;
        end
    end

    assign stat.bad        = bad_reg;
    assign stat.terms_done = (term_reg == k_eff);

    // ---------------- multiply stage ----------------
    logic [7:0]              mea, meb, mea_x, meb_x;
    logic                    ma_nan, mb_nan, ma_inf, mb_inf, ma_zero, mb_zero;
    logic [23:0]             ma, mb;
    fkind_t                  mkind_next;
    fkind_t                  mkind_reg;
    logic                    msign_reg;
    logic signed [EXP_W-1:0] mexp_reg;
    logic [47:0]             mprod_reg;

    assign mea     = a_rd_reg[30:23];
    assign meb     = b_rd_reg[30:23];
    assign ma_nan  = (&mea) && (|a_rd_reg[22:0]);
    assign mb_nan  = (&meb) && (|b_rd_reg[22:0]);
    assign ma_inf  = (&mea) && !(|a_rd_reg[22:0]);
    assign mb_inf  = (&meb) && !(|b_rd_reg[22:0]);
    assign ma_zero = !(|a_rd_reg[30:0]);
    assign mb_zero = !(|b_rd_reg[30:0]);
    assign ma      = {|mea, a_rd_reg[22:0]};
    assign mb      = {|meb, b_rd_reg[22:0]};
    assign mea_x   = (|mea) ? mea : 8'd1;
    assign meb_x   = (|meb) ? meb : 8'd1;

    always_comb
    begin
        if (ma_nan || mb_nan || (ma_inf && mb_zero) || (mb_inf && ma_zero))
            mkind_next = FK_NAN;
        else if (ma_inf || mb_inf)
            mkind_next = FK_INF;
        else if (ma_zero || mb_zero)
            mkind_next = FK_ZERO;
        else
            mkind_next = FK_NUM;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            mkind_reg <= mkind_next;
            msign_reg <= a_rd_reg[31] ^ b_rd_reg[31];
            mexp_reg  <= $signed({4'b0, mea_x}) + $signed({4'b0, meb_x}) - 12'sd126;
            mprod_reg <= 48'(ma) * 48'(mb);
        end
    end

    // ---------------- align and add stage ----------------
    logic [31:0]             acc_reg, prod_reg;
    logic                    x_nan, y_nan, x_inf, y_inf, x_big;
    logic [31:0]             big_v, sml_v;
    logic [7:0]              eb_x, es_x, dsh;
    logic [SUM_W-1:0]        big_w, sml_a, sum_w;
    logic [2*SUM_W-1:0]      sml_wide;
    fkind_t                  akind_next;
    logic                    asign_next;
    fkind_t                  akind_reg;
    logic                    asign_reg;
    logic signed [EXP_W-1:0] aexp_reg;
    logic [SUM_W-1:0]        asum_reg;

    assign x_nan = (&acc_reg[30:23]) && (|acc_reg[22:0]);
    assign y_nan = (&prod_reg[30:23]) && (|prod_reg[22:0]);
    assign x_inf = (&acc_reg[30:23]) && !(|acc_reg[22:0]);
    assign y_inf = (&prod_reg[30:23]) && !(|prod_reg[22:0]);
    assign x_big = acc_reg[30:0] >= prod_reg[30:0];
    assign big_v = x_big ? acc_reg : prod_reg;
    assign sml_v = x_big ? prod_reg : acc_reg;
    assign eb_x  = (|big_v[30:23]) ? big_v[30:23] : 8'd1;
    assign es_x  = (|sml_v[30:23]) ? sml_v[30:23] : 8'd1;
    assign dsh   = eb_x - es_x;
    assign big_w = {1'b0, |big_v[30:23], big_v[22:0], 25'b0};
    assign sml_wide = {1'b0, |sml_v[30:23], sml_v[22:0], 25'b0, {SUM_W{1'b0}}} >> dsh;
    assign sml_a = {sml_wide[2*SUM_W-1:SUM_W+1],
                    sml_wide[SUM_W] | (|sml_wide[SUM_W-1:0])};
    assign sum_w = (big_v[31] == sml_v[31]) ? big_w + sml_a : big_w - sml_a;

    always_comb
    begin
        asign_next = big_v[31];
        if (x_nan || y_nan || (x_inf && y_inf && acc_reg[31] != prod_reg[31]))
            akind_next = FK_NAN;
        else if (x_inf)
        begin
            akind_next = FK_INF;
            asign_next = acc_reg[31];
        end
        else if (y_inf)
        begin
            akind_next = FK_INF;
            asign_next = prod_reg[31];
        end
        else if (sum_w == '0)
        begin
            // exact zero: negative only when both operands are negative
            akind_next = FK_ZERO;
            asign_next = acc_reg[31] & prod_reg[31];
        end
        else
            akind_next = FK_NUM;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.add)
        begin
            akind_reg <= akind_next;
            asign_reg <= asign_next;
            aexp_reg  <= $signed({4'b0, eb_x}) + 12'sd1;
            asum_reg  <= sum_w;
        end
    end

    // ---------------- shared normalize stage ----------------
    fkind_t                  nin_kind;
    logic                    nin_sign;
    logic signed [EXP_W-1:0] nin_exp;
    logic [SUM_W-1:0]        nin_mant, nsh;
    logic [5:0]              nlz;
    fkind_t                  nkind_reg;
    logic                    nsign_reg;
    logic signed [EXP_W-1:0] nexp_reg;
    logic [47:0]             nmant_reg;
    logic                    nstk_reg;

    assign nin_kind = cmd.norm_add ? akind_reg : mkind_reg;
    assign nin_sign = cmd.norm_add ? asign_reg : msign_reg;
    assign nin_exp  = cmd.norm_add ? aexp_reg  : mexp_reg;
    assign nin_mant = cmd.norm_add ? asum_reg  : {mprod_reg, 2'b00};
    assign nlz      = lzc(nin_mant);
    assign nsh      = nin_mant << nlz;

    always_ff @(posedge clk)
    begin
        if (cmd.norm)
        begin
            nkind_reg <= nin_kind;
            nsign_reg <= nin_sign;
            nexp_reg  <= nin_exp - $signed(EXP_W'(nlz));
            nmant_reg <= nsh[SUM_W-1:2];
            nstk_reg  <= |nsh[1:0];
        end
    end

    // ---------------- round and pack ----------------
    logic [31:0] rnd_val;

    always_comb
    begin
        case (nkind_reg)
            FK_NAN:  rnd_val = CANON_NAN;
            FK_INF:  rnd_val = {nsign_reg, 8'hFF, 23'b0};
            FK_ZERO: rnd_val = {nsign_reg, 31'b0};
            default: rnd_val = round_pack(nsign_reg, nexp_reg, nmant_reg, nstk_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prod_en)
            prod_reg <= rnd_val;
        if (cmd.load)
            acc_reg <= 32'h0;
        else if (cmd.acc_en)
            acc_reg <= rnd_val;
    end

    // ---------------- result ----------------
    assign result_value = bad_reg ? 32'h0 : acc_reg;
    assign result_row   = row_reg;
    assign result_col   = col_reg;
    assign index_error  = bad_reg;

endmodule

`default_nettype wire

/* hdl/matrix_multiply_transpose_modes_top.sv */
// ============================================================================
// matrix_multiply_transpose_modes_top
// Single-precision matrix product engine C = op(A) x op(B) with three
// layout modes; element stores loaded by the host, one result per read.
// ============================================================================
//
//  Channel   Signals                                         Handshake
//  --------  ----------------------------------------------  ----------------
//  request   req_type elem_index elem_value out_row out_col  start & !busy
//  result    result_value result_row result_col index_error  done, one cycle
//  config    cfg_index cfg_data                              cfg_valid&ready
//
//  A write goes straight into its store; busy stays low.
//  A read holds busy while each term goes fetch, multiply, normalize,
//  round, add, normalize, round through one shared normalizer, and the
//  accumulator feeds back into the next add. Out-of-range reads and K = 0
//  go from check to done. The result shows on done for one cycle and the
//  receiver cannot stall it. Reset clears control and configuration only.
//
`default_nettype none

module matrix_multiply_transpose_modes_top
    import mmt_pkg::*;
#(
    parameter int MAX_DIM = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [11:0] elem_index,
    input  logic [31:0] elem_value,
    input  logic [5:0]  out_row,
    input  logic [5:0]  out_col,
    output logic        done,
    output logic [31:0] result_value,
    output logic [5:0]  result_row,
    output logic [5:0]  result_col,
    output logic        index_error,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;
    logic      accept;

    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    mmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .stat     (stat),
        .busy     (busy),
        .done     (done),
        .cmd      (cmd)
    );

    mmt_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .req_type     (req_type),
        .elem_index   (elem_index),
        .elem_value   (elem_value),
        .out_row      (out_row),
        .out_col      (out_col),
        .cmd          (cmd),
        .stat         (stat),
        .result_value (result_value),
        .result_row   (result_row),
        .result_col   (result_col),
        .index_error  (index_error)
    );

endmodule

`default_nettype wire

/* hdl/mmt_checker.sv */
// ============================================================================
// mmt_checker
// Port-level checks on the request/result sequencing of the engine.
// ============================================================================
`default_nettype none

module mmt_checker
    import mmt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  req_type,
    input logic        done,
    input logic [31:0] result_value,
    input logic        index_error
);

    // a result only appears while a read is in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe without a read in flight");

    // an accepted read transfer makes the engine busy
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_READ) |=> busy)
        else $error("read accepted but engine not busy");

    // one strobe per read, then the engine is free again
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe not followed by idle");

    // out-of-range reads return zero
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && index_error) |-> (result_value == 32'h0))
        else $error("index error with nonzero value");

endmodule

bind matrix_multiply_transpose_modes_top mmt_checker u_mmt_checker (.*);

`default_nettype wire
